>>> rtl/box_iou_cost_engine_assert.svh
// Assertion macros shared by the box IoU cost engine modules.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef BOX_IOU_COST_ENGINE_ASSERT_SVH
`define BOX_IOU_COST_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BIC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BIC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/bic_pkg.sv
// Shared types and constants of the box IoU cost engine.
// No dependencies; every module of the engine imports this package.
package bic_pkg;

    // Request codes carried in req_type.
    localparam logic REQ_APPEND = 1'b0;
    localparam logic REQ_SCORE  = 1'b1;

    // IoU is a Q1.16 fraction; one is 2^16 and needs 17 bits.
    localparam int          IOU_W       = 17;
    localparam logic [16:0] IOU_ONE     = 17'h10000;
    localparam logic [16:0] GATE_RESET  = 17'd6554;
    localparam int          REF_INDEX_W = 5;

    // Operand widths of the overlap arithmetic.
    localparam int EXT_W   = 15;              // clamped extent and box size
    localparam int AREA_W  = 2 * EXT_W;       // one area or the intersection
    localparam int UNION_W = AREA_W + 1;      // sum of two areas
    localparam int REM_W   = UNION_W + 1;     // divider partial remainder

    typedef struct packed {
        logic        req_type;
        logic        frame_start;
        logic [15:0] box_left;
        logic [15:0] box_top;
        logic [14:0] box_width;
        logic [14:0] box_height;
    } req_t;

    typedef struct packed {
        logic [REF_INDEX_W-1:0] ref_index;
        logic [IOU_W-1:0]       cost;
        logic                   gate_pass;
        logic                   row_last;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic det_load;   // capture the detection box of a score request
        logic wr_en;      // store the request box in the reference table
        logic rd_en;      // read one reference box into the pipeline
        logic rd_last;    // that box is the last stored one
    } ctl_cmd_t;

endpackage

>>> rtl/box_iou_cost_engine.sv
// Top level of the box IoU cost engine.
// Depends on bic_pkg, bic_ctrl and bic_datapath.

// The engine keeps a table of up to MAX_REF_BOXES reference rectangles and scores
// detection rectangles against it. A request beat is taken at a rising clock edge
// where start is high and busy is low. An append beat (req_type 0) stores its box at
// the end of the table in that one cycle; with frame_start set the table is emptied
// first, and an append to a full table is dropped. A score beat (req_type 1) produces
// one result beat per stored box, in table order, with cost = 1 - IoU in Q1.16
// (65536 means no overlap), gate_pass when IoU is above iou_gate, and row_last on the
// beat of the last stored box; an empty table yields no result. Result beats appear on
// rsp with rsp_valid high for exactly one cycle each and cannot be held off, so the
// receiver must take one beat per cycle. The stored boxes are read one per cycle into
// a pipeline of three arithmetic stages and a 17-stage restoring divider (one quotient
// bit per stage); the results follow back to back, and busy stays high until the
// pipeline has drained. The iou_gate register is written through cfg_we and cfg_wdata
// and resets to 6554 (about 0.1); write it only while busy is low. The table itself
// has no reset: only entries below the fill count are ever read.

module box_iou_cost_engine
    import bic_pkg::*;
#(
    parameter int MAX_REF_BOXES = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  req_t              req,
    input  logic              cfg_we,
    input  logic [IOU_W-1:0]  cfg_wdata,
    output logic              rsp_valid,
    output rsp_t              rsp
);

    localparam int IDX_W = (MAX_REF_BOXES > 1) ? $clog2(MAX_REF_BOXES) : 1;

    ctl_cmd_t         cmd;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    logic             pipe_empty;

    // The controller owns the fill count and walks the table on a score beat.
    bic_ctrl #(
        .MAX_REF_BOXES (MAX_REF_BOXES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .req        (req),
        .pipe_empty (pipe_empty),
        .busy       (busy),
        .cmd        (cmd),
        .wr_addr    (wr_addr),
        .rd_addr    (rd_addr)
    );

    // The datapath holds the table, the gate register and the scoring pipeline.
    bic_datapath #(
        .MAX_REF_BOXES (MAX_REF_BOXES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .cmd        (cmd),
        .wr_addr    (wr_addr),
        .rd_addr    (rd_addr),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .pipe_empty (pipe_empty),
        .rsp_valid  (rsp_valid),
        .rsp        (rsp)
    );

endmodule

>>> rtl/bic_ctrl.sv
// Controller of the box IoU cost engine: request decode, table fill count, scan sequencing.
// Depends on bic_pkg and the assertion macros in box_iou_cost_engine_assert.svh.
`include "box_iou_cost_engine_assert.svh"

module bic_ctrl
    import bic_pkg::*;
#(
    parameter int  MAX_REF_BOXES = 32,
    localparam int IDX_W         = (MAX_REF_BOXES > 1) ? $clog2(MAX_REF_BOXES) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  req_t                 req,
    input  logic                 pipe_empty,
    output logic                 busy,
    output ctl_cmd_t             cmd,
    output logic [IDX_W-1:0]     wr_addr,
    output logic [IDX_W-1:0]     rd_addr
);

    localparam int CNT_W = $clog2(MAX_REF_BOXES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REF_BOXES);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             accept;
    logic [CNT_W-1:0] base;
    logic             room;
    logic             scan_last;

    assign accept    = start && (state_reg == ST_IDLE);
    assign base      = req.frame_start ? '0 : count_reg;
    assign room      = (base < CNT_MAX);
    assign scan_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign busy      = (state_reg != ST_IDLE);
    assign wr_addr   = base[IDX_W-1:0];
    assign rd_addr   = idx_reg;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req.req_type == REQ_APPEND))
                begin
                    cmd.wr_en  = room;
                    count_next = room ? (base + CNT_W'(1)) : base;
                end
                else if (accept)
                begin
                    cmd.det_load = 1'b1;
                    idx_next     = '0;
                    if (count_reg != '0)
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_last = scan_last;
                if (scan_last)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (pipe_empty)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    `BIC_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_MAX, "fill count above table size")
    `BIC_ASSERT_NOW(a_scan_in_table, state_reg == ST_SCAN, CNT_W'(idx_reg) < count_reg, "bad index")
    `BIC_ASSERT_NEXT(a_last_to_drain, cmd.rd_en && cmd.rd_last, state_reg == ST_DRAIN, "no drain")

endmodule

>>> rtl/bic_datapath.sv
// Datapath of the box IoU cost engine: reference table, overlap arithmetic,
// pipelined restoring divider and result register. Depends on bic_pkg and the assertion macros.
`include "box_iou_cost_engine_assert.svh"

module bic_datapath
    import bic_pkg::*;
#(
    parameter int  MAX_REF_BOXES = 32,
    localparam int IDX_W         = (MAX_REF_BOXES > 1) ? $clog2(MAX_REF_BOXES) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  req_t                 req,
    input  ctl_cmd_t             cmd,
    input  logic [IDX_W-1:0]     wr_addr,
    input  logic [IDX_W-1:0]     rd_addr,
    input  logic                 cfg_we,
    input  logic [IOU_W-1:0]     cfg_wdata,
    output logic                 pipe_empty,
    output logic                 rsp_valid,
    output rsp_t                 rsp
);

    // Stage positions: table read, extents, products, union, then one per quotient bit.
    localparam int S_UNI = 3;
    localparam int NSTG  = S_UNI + 1 + IOU_W;

    typedef struct packed {
        logic [15:0] box_left;
        logic [15:0] box_top;
        logic [14:0] box_width;
        logic [14:0] box_height;
    } box_t;

    box_t             ref_mem [0:MAX_REF_BOXES-1];
    box_t             ref_rd_reg;
    box_t             det_reg;
    box_t             req_box;
    logic [IOU_W-1:0] gate_reg;

    logic [NSTG-1:0]  vld_reg;
    logic [NSTG-1:0]  last_reg;
    logic [IDX_W-1:0] idx_reg [0:NSTG-1];

    // Extent stage.
    logic signed [16:0] r_lo_x, r_lo_y, r_hi_x, r_hi_y;
    logic signed [16:0] d_lo_x, d_lo_y, d_hi_x, d_hi_y;
    logic signed [16:0] x1, y1, x2, y2;
    logic signed [17:0] dx, dy;
    logic [EXT_W-1:0]   iw_reg, ih_reg, rw_reg, rh_reg;

    // Product stage.
    logic [AREA_W-1:0]  inter_reg, area_r_reg, area_d_reg;

    // Divider stages; index 0 is the union stage.
    logic [REM_W-1:0]   dv_rem_reg [0:IOU_W];
    logic [UNION_W-1:0] dv_den_reg [0:IOU_W];
    logic [IOU_W-1:0]   dv_quo_reg [0:IOU_W];
    logic               dv_zero_reg [0:IOU_W];

    logic [IOU_W-1:0]   iou;

    assign req_box = '{box_left:   req.box_left,
                       box_top:    req.box_top,
                       box_width:  req.box_width,
                       box_height: req.box_height};

    // Reference table and detection box.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            ref_mem[wr_addr] <= req_box;
        end
        if (cmd.rd_en)
        begin
            ref_rd_reg <= ref_mem[rd_addr];
        end
        if (cmd.det_load)
        begin
            det_reg <= req_box;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_reg <= GATE_RESET;
        end
        else if (cfg_we)
        begin
            gate_reg <= cfg_wdata;
        end
    end

    // Valid and row-end bits travel alongside the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[NSTG-2:0], cmd.rd_en};
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg   <= {last_reg[NSTG-2:0], cmd.rd_last};
        idx_reg[0] <= rd_addr;
        for (int i = 1; i < NSTG; i++)
        begin
            idx_reg[i] <= idx_reg[i-1];
        end
    end

    assign pipe_empty = (vld_reg == '0);

    // Overlap extents, clamped at zero.
    always_comb
    begin
        r_lo_x = {ref_rd_reg.box_left[15], ref_rd_reg.box_left};
        r_lo_y = {ref_rd_reg.box_top[15], ref_rd_reg.box_top};
        d_lo_x = {det_reg.box_left[15], det_reg.box_left};
        d_lo_y = {det_reg.box_top[15], det_reg.box_top};
        r_hi_x = r_lo_x + {2'b00, ref_rd_reg.box_width};
        r_hi_y = r_lo_y + {2'b00, ref_rd_reg.box_height};
        d_hi_x = d_lo_x + {2'b00, det_reg.box_width};
        d_hi_y = d_lo_y + {2'b00, det_reg.box_height};
        x1 = (r_lo_x > d_lo_x) ? r_lo_x : d_lo_x;
        y1 = (r_lo_y > d_lo_y) ? r_lo_y : d_lo_y;
        x2 = (r_hi_x < d_hi_x) ? r_hi_x : d_hi_x;
        y2 = (r_hi_y < d_hi_y) ? r_hi_y : d_hi_y;
        dx = {x2[16], x2} - {x1[16], x1};
        dy = {y2[16], y2} - {y1[16], y1};
    end

    always_ff @(posedge clk)
    begin
        iw_reg <= (dx > 18'sd0) ? dx[EXT_W-1:0] : '0;
        ih_reg <= (dy > 18'sd0) ? dy[EXT_W-1:0] : '0;
        rw_reg <= ref_rd_reg.box_width;
        rh_reg <= ref_rd_reg.box_height;
    end

    always_ff @(posedge clk)
    begin
        inter_reg  <= AREA_W'(iw_reg) * AREA_W'(ih_reg);
        area_r_reg <= AREA_W'(rw_reg) * AREA_W'(rh_reg);
        area_d_reg <= AREA_W'(det_reg.box_width) * AREA_W'(det_reg.box_height);
    end

    // Union stage feeds the divider; the union never goes negative.
    always_ff @(posedge clk)
    begin
        dv_rem_reg[0]  <= REM_W'(inter_reg);
        dv_den_reg[0]  <= UNION_W'(area_r_reg) + UNION_W'(area_d_reg) - UNION_W'(inter_reg);
        dv_quo_reg[0]  <= '0;
        dv_zero_reg[0] <= ((UNION_W'(area_r_reg) + UNION_W'(area_d_reg)) == UNION_W'(inter_reg));
    end

    // One quotient bit per stage. The first stage tests inter >= union, which is
    // the integer bit of the Q1.16 result; later stages double the remainder.
    for (genvar k = 1; k <= IOU_W; k++)
    begin : g_div
        logic [REM_W-1:0] trial;
        logic             take;

        always_comb
        begin
            if (k == 1)
            begin
                trial = dv_rem_reg[k-1];
            end
            else
            begin
                trial = {dv_rem_reg[k-1][REM_W-2:0], 1'b0};
            end
            take = (trial >= REM_W'(dv_den_reg[k-1]));
        end

        always_ff @(posedge clk)
        begin
            dv_rem_reg[k]  <= take ? (trial - REM_W'(dv_den_reg[k-1])) : trial;
            dv_den_reg[k]  <= dv_den_reg[k-1];
            dv_quo_reg[k]  <= {dv_quo_reg[k-1][IOU_W-2:0], take};
            dv_zero_reg[k] <= dv_zero_reg[k-1];
        end
    end

    // With both areas zero the quotient is meaningless; IoU is defined as zero.
    assign iou = dv_zero_reg[IOU_W] ? '0 : dv_quo_reg[IOU_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid <= 1'b0;
        end
        else
        begin
            rsp_valid <= vld_reg[NSTG-1];
        end
    end

    always_ff @(posedge clk)
    begin
        rsp.ref_index <= REF_INDEX_W'(idx_reg[NSTG-1]);
        rsp.cost      <= IOU_ONE - iou;
        rsp.gate_pass <= (iou > gate_reg);
        rsp.row_last  <= last_reg[NSTG-1];
    end

    `BIC_ASSERT_NOW(a_cost_range, rsp_valid, rsp.cost <= IOU_ONE, "cost above one")
    `BIC_ASSERT_NOW(a_gate_overlap, rsp_valid && rsp.gate_pass, rsp.cost != IOU_ONE, "gate no overlap")
    `BIC_ASSERT_NOW(a_zero_union, vld_reg[S_UNI] && dv_zero_reg[0], dv_rem_reg[0] == '0, "bad union")

endmodule
